[src/stkal_pkg.sv]
// stkal_pkg: shared constants, types and codes of the stack allocator
// used by stkal_pad_mem and stack_allocator_aligned_unit; no dependencies
package stkal_pkg;

    localparam int unsigned POOL_BYTES     = 4096;
    localparam int unsigned POOL_AW        = $clog2(POOL_BYTES);
    localparam int unsigned HEADER_BYTES   = 8;
    localparam int unsigned MAX_ALIGN_LOG2 = 7;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned OFF_W   = 13;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned PAD_W   = 8;
    localparam int unsigned LG_W    = 3;
    localparam int unsigned MASK_W  = 7;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic               en;
        logic [POOL_AW-1:0] addr;
        logic [PAD_W-1:0]   data;
    } t_pad_wr;

endpackage

[src/stkal_pad_mem.sv]
// stkal_pad_mem: header padding store, one write and one registered read port
// depends on stkal_pkg
module stkal_pad_mem
    import stkal_pkg::*;
(
    input  logic               i_clk,
    input  t_pad_wr            i_wr,
    input  logic [POOL_AW-1:0] i_raddr,
    output logic [PAD_W-1:0]   o_rdata
);

    logic [PAD_W-1:0] r_mem [POOL_BYTES];
    logic [PAD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/stack_allocator_aligned_unit.sv]
// stack_allocator_aligned_unit: bump pointer stack allocator with alignment headers
// allocate, clear and unused mode register their item the cycle after acceptance; free first waits
// in S_FREE for the padding read from the header memory, and its item is registered after that
// throughput: one item per cycle for allocate and clear while the result port is not stalled;
// no item is taken in S_FREE. reset (synchronous, active low): empty pool, base 0, limit 4096;
// header memory not cleared; depends on stkal_pkg and stkal_pad_mem
module stack_allocator_aligned_unit
    import stkal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // request_size[12:0], align_log2[15:13], block_address[47:16]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // result_address[31:0], used_bytes[44:32], live_count[56:45], zero
    output logic [0:0]  m_axis_tuser   // failed[0]
);

    typedef enum logic {
        S_IDLE,
        S_FREE
    } t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_base;
    logic [OFF_W-1:0]     r_limit;
    logic [OFF_W-1:0]     r_top,   n_top;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_out_addr, n_out_addr;
    logic                 r_out_fail, n_out_fail;
    logic [OFF_W-1:0]     r_foff;
    logic                 r_fok;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_cfg_wr;
    t_mode                w_mode;
    logic [OFF_W-1:0]     w_size;
    logic [LG_W-1:0]      w_lg;
    logic [ADDR_W-1:0]    w_baddr;

    logic [MASK_W-1:0]    w_mask;
    logic [MASK_W-1:0]    w_mis;
    logic [MASK_W-1:0]    w_pad0;
    logic [PAD_W-1:0]     w_need;
    logic [PAD_W-1:0]     w_pad;
    logic [OFF_W-1:0]     w_eff_limit;
    logic [OFF_W+1:0]     w_total;
    logic                 w_fit;
    logic [OFF_W-1:0]     w_aoff;
    logic [ADDR_W-1:0]    w_foff;
    logic                 w_fcond;
    logic [PAD_W-1:0]     w_rpad;
    t_pad_wr              w_wr;

    assign w_mode  = t_mode'(s_axis_tuser);
    assign w_size  = s_axis_tdata[12:0];
    assign w_lg    = (s_axis_tdata[15:13] > LG_W'(MAX_ALIGN_LOG2)) ?
                     LG_W'(MAX_ALIGN_LOG2) : s_axis_tdata[15:13];
    assign w_baddr = s_axis_tdata[47:16];

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_BASE:  prdata = r_base;
            REG_LIMIT: prdata = {19'd0, r_limit};
            default:   prdata = '0;
        endcase
    end

    // alignment padding with room for the header
    always_comb begin
        w_mask = MASK_W'((8'd1 << w_lg) - 8'd1);
        w_mis  = (r_base[MASK_W-1:0] + r_top[MASK_W-1:0]) & w_mask;
        w_pad0 = MASK_W'(MASK_W'(0) - w_mis) & w_mask;
        w_need = '0;
        if ({1'b0, w_pad0} < PAD_W'(HEADER_BYTES)) begin
            w_need = PAD_W'(HEADER_BYTES) - {1'b0, w_pad0};
            w_need = ((w_need + {1'b0, w_mask}) >> w_lg) << w_lg;
        end
        w_pad = {1'b0, w_pad0} + w_need;
    end

    assign w_eff_limit = (r_limit > OFF_W'(POOL_BYTES)) ? OFF_W'(POOL_BYTES) : r_limit;
    assign w_total     = {7'd0, w_pad} + {2'd0, w_size} + {2'd0, r_top};
    assign w_fit       = (w_size != '0) && (w_total <= {2'd0, w_eff_limit});
    assign w_aoff      = r_top + {5'd0, w_pad};

    assign w_foff  = w_baddr - r_base;
    assign w_fcond = (r_count != '0) && (w_foff < {19'd0, r_top})
                     && (w_foff < ADDR_W'(POOL_BYTES));

    always_comb begin
        w_wr.en   = w_accept && (w_mode == MODE_ALLOC) && w_fit
                    && (w_aoff < OFF_W'(POOL_BYTES));
        w_wr.addr = w_aoff[POOL_AW-1:0];
        w_wr.data = w_pad;
    end

    stkal_pad_mem u_pad_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_foff[POOL_AW-1:0]),
        .o_rdata (w_rpad)
    );

    always_comb begin
        n_top      = r_top;
        n_count    = r_count;
        n_out_addr = '0;
        n_out_fail = 1'b0;
        if (r_state == S_FREE) begin
            if (r_fok && ({5'd0, w_rpad} <= r_foff)) begin
                n_top   = r_foff - {5'd0, w_rpad};
                n_count = r_count - COUNT_W'(1);
            end
        end else if (w_accept) begin
            unique case (w_mode)
                MODE_ALLOC: begin
                    if (w_fit) begin
                        n_top      = w_aoff + w_size;
                        n_count    = r_count + COUNT_W'(1);
                        n_out_addr = r_base + {19'd0, w_aoff};
                    end else begin
                        n_out_fail = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    n_top   = '0;
                    n_count = '0;
                end
                MODE_FREE, MODE_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_limit     <= OFF_W'(POOL_BYTES);
            r_top       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_fok       <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_BASE:  r_base  <= pwdata;
                    REG_LIMIT: r_limit <= pwdata[OFF_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_top   <= n_top;
            r_count <= n_count;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_mode == MODE_FREE) begin
                            r_state     <= S_FREE;
                            r_fok       <= w_fcond;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_FREE: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_foff <= w_foff[OFF_W-1:0];
        end
        if ((r_state == S_FREE) || (w_accept && (w_mode != MODE_FREE))) begin
            r_out_addr <= n_out_addr;
            r_out_fail <= n_out_fail;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_count, r_top, r_out_addr};
    assign m_axis_tuser  = r_out_fail;

    // checks
    a_free_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |-> !r_out_valid)
        else $error("result pending during free read");

    a_free_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_mode == MODE_FREE)) |=> (r_state == S_FREE))
        else $error("free item did not wait for header read");

    a_top_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= OFF_W'(POOL_BYTES))
        else $error("top offset beyond pool");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fail) |-> (r_out_addr == '0))
        else $error("failed item carries an address");

endmodule

[verif/tb.sv]
// tb: self-checking bench for stack_allocator_aligned_unit, random and directed
// allocate/free/clear/unused-mode items against an in-bench allocator prediction, apb config phases
// depends on stkal_pkg and the rtl under src
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stkal_pkg::*;

    typedef struct packed {
        t_mode             mode;
        logic [OFF_W-1:0]  size;
        logic [LG_W-1:0]   align_lg;
        logic [ADDR_W-1:0] blk_addr;
    } t_alloc_req;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic               failed;
        logic [OFF_W-1:0]   used;
        logic [COUNT_W-1:0] live;
    } t_alloc_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // request_size, align_log2, block_address
    logic [1:0]  s_axis_tuser = '0;  // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // result_address, used_bytes, live_count, zero
    logic [0:0]  m_axis_tuser;       // failed

    stack_allocator_aligned_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // allocator shadow state
    logic [ADDR_W-1:0]  pool_base = '0;
    logic [OFF_W-1:0]   pool_cap = 13'd4096;
    logic [OFF_W-1:0]   top_off = '0;
    logic [COUNT_W-1:0] live_blocks = '0;
    logic [PAD_W-1:0]   pad_hdr [POOL_BYTES];
    bit                 hdr_valid [POOL_BYTES];

    t_alloc_req        req_pending [$];
    t_alloc_rsp        rsp_expected [$];
    logic [ADDR_W-1:0] live_addrs [$];
    t_alloc_req        req_head;
    t_alloc_rsp        rsp_want;

    int unsigned errors = 0;
    int unsigned tick = 0;
    int unsigned rsp_count = 0;
    int unsigned req_gap = 0;
    int unsigned rsp_gap = 0;
    int unsigned hold_cnt = 0;
    bit          held_off = 1'b0;
    bit          calm_req = 1'b0;
    bit          calm_rsp = 1'b0;
    bit          req_took = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_alloc_rsp apply_request(t_alloc_req rq);
        t_alloc_rsp  rs;
        int unsigned lg, align, mis, pad, lim, off;
        rs = '0;
        case (rq.mode)
            MODE_ALLOC: begin
                lg = (rq.align_lg > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : rq.align_lg;
                align = 1 << lg;
                mis = (pool_base + top_off) & (align - 1);
                pad = (align - mis) & (align - 1);
                if (pad < HEADER_BYTES)
                    pad += ((HEADER_BYTES - pad + align - 1) >> lg) << lg;
                lim = (pool_cap > POOL_BYTES) ? POOL_BYTES : pool_cap;
                if (rq.size == 0 || pad + rq.size + top_off > lim) begin
                    rs.failed = 1'b1;
                end else begin
                    off = top_off + pad;
                    pad_hdr[off] = PAD_W'(pad);
                    hdr_valid[off] = 1'b1;
                    top_off = OFF_W'(off + rq.size);
                    live_blocks = live_blocks + 1'b1;
                    rs.addr = pool_base + off;
                end
            end
            MODE_FREE: begin
                off = rq.blk_addr - pool_base;
                if (live_blocks != 0 && off < top_off && off < POOL_BYTES) begin
                    if (pad_hdr[off] <= off) begin
                        top_off = OFF_W'(off - pad_hdr[off]);
                        live_blocks = live_blocks - 1'b1;
                    end
                end
            end
            MODE_CLEAR: begin
                top_off = '0;
                live_blocks = '0;
            end
            default: ;
        endcase
        rs.used = top_off;
        rs.live = live_blocks;
        return rs;
    endfunction

    // a free that would look up a header slot no allocation has filled
    function automatic bit reads_blank(logic [ADDR_W-1:0] a);
        int unsigned off;
        off = a - pool_base;
        if (live_blocks == 0 || off >= top_off || off >= POOL_BYTES)
            return 1'b0;
        return !hdr_valid[off];
    endfunction

    function automatic void queue_request(t_mode m, int unsigned sz, int unsigned lg,
                                          logic [ADDR_W-1:0] a);
        t_alloc_req rq;
        t_alloc_rsp rs;
        rq.mode = m;
        rq.size = OFF_W'(sz);
        rq.align_lg = LG_W'(lg);
        rq.blk_addr = a;
        if (m == MODE_FREE && reads_blank(a))
            rq.blk_addr = pool_base + top_off;
        rs = apply_request(rq);
        req_pending.push_back(rq);
        rsp_expected.push_back(rs);
        if (m == MODE_ALLOC && !rs.failed)
            live_addrs.push_back(rs.addr);
        if (live_blocks == 0)
            live_addrs.delete();
        while (live_addrs.size() != 0 && (live_addrs[$] - pool_base) >= top_off)
            void'(live_addrs.pop_back());
    endfunction

    function automatic void queue_random();
        int unsigned       r, sz;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(99);
        a = $urandom;
        if (r < 52) begin
            r = $urandom_range(99);
            if (r < 3)
                sz = 0;
            else if (r < 6)
                sz = 4096;
            else if (r < 12)
                sz = $urandom_range(4096);
            else
                sz = $urandom_range(1, 160);
            queue_request(MODE_ALLOC, sz, $urandom_range(7), a);
        end else if (r < 95) begin
            r = $urandom_range(99);
            if (live_addrs.size() != 0 && r < 75)
                a = live_addrs[$];
            else if (live_addrs.size() != 0 && r < 85)
                a = live_addrs[$urandom_range(live_addrs.size() - 1)];
            else if (r < 93)
                a = pool_base + $urandom_range(4200);
            queue_request(MODE_FREE, $urandom_range(4096), $urandom_range(7), a);
        end else if (r < 97) begin
            queue_request(MODE_CLEAR, $urandom_range(4096), $urandom_range(7), a);
        end else begin
            queue_request(MODE_NONE, $urandom_range(4096), $urandom_range(7), a);
        end
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdat,
                            output logic [31:0] rdat);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdat;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdat = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        logic [31:0] back;
        apb_xfer(1'b1, idx, val, back);
        apb_xfer(1'b0, idx, '0, back);
        check_field("register readback", val, back);
        if (idx == REG_BASE)
            pool_base = val;
        else
            pool_cap = val[OFF_W-1:0];
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || rsp_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [31:0] limit,
                             input int unsigned n);
        wait_drained();
        write_reg(REG_BASE, base);
        write_reg(REG_LIMIT, limit);
        repeat (n) queue_random();
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (tick % 180 == 0)
            calm_req = ($urandom_range(3) == 0);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_took) begin
            if (req_gap != 0) begin
                req_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (req_pending.size() != 0) begin
                req_head = req_pending[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {req_head.blk_addr, req_head.align_lg, req_head.size};
                s_axis_tuser <= req_head.mode;
                req_gap = pick_gap(calm_req);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (tick % 160 == 0)
            calm_rsp = ($urandom_range(3) == 0);
        if (!held_off && rsp_count >= 500) begin
            held_off = 1'b1;
            hold_cnt = 300;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (rsp_gap != 0) begin
            rsp_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rsp_gap = ($urandom_range(99) < 20) ? pick_gap(calm_rsp) : 0;
        end
    end

    // handshake monitor and result check
    always @(posedge i_clk) begin
        tick++;
        req_took = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (req_took)
            req_pending.delete(0);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rsp_count++;
            if (rsp_expected.size() == 0) begin
                $display("%0t ns: item with none expected, expected nothing, got %0h/%0h",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                rsp_want = rsp_expected.pop_front();
                check_field("result_address", rsp_want.addr, m_axis_tdata[31:0]);
                check_field("failed", rsp_want.failed, m_axis_tuser[0]);
                check_field("used_bytes", rsp_want.used, m_axis_tdata[44:32]);
                check_field("live_count", rsp_want.live, m_axis_tdata[56:45]);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset configuration
        queue_request(MODE_FREE, $urandom_range(4096), $urandom_range(7), $urandom);
        queue_request(MODE_ALLOC, 0, 3, $urandom);
        queue_request(MODE_ALLOC, 1, 0, $urandom);
        queue_request(MODE_ALLOC, 5, 7, $urandom);
        queue_request(MODE_ALLOC, 4096, 0, $urandom);
        queue_request(MODE_FREE, 4096, 7, 32'hFFFF_FFFF);
        queue_request(MODE_FREE, 0, 0, pool_base + top_off);
        queue_request(MODE_NONE, 4096, 7, $urandom);
        queue_request(MODE_FREE, 0, 0, live_addrs[$]);
        queue_request(MODE_ALLOC, 7, 3, $urandom);
        queue_request(MODE_ALLOC, 100, 4, $urandom);
        queue_request(MODE_ALLOC, 33, 6, $urandom);
        queue_request(MODE_FREE, 0, 0, live_addrs[0]);
        queue_request(MODE_CLEAR, $urandom_range(4096), $urandom_range(7), $urandom);
        queue_request(MODE_ALLOC, 4088, 0, $urandom);
        queue_request(MODE_ALLOC, 1, 0, $urandom);
        queue_request(MODE_FREE, 0, 0, live_addrs[$]);
        queue_request(MODE_ALLOC, 4089, 0, $urandom);
        queue_request(MODE_ALLOC, 4096, 2, $urandom);
        queue_request(MODE_ALLOC, 2048, 5, $urandom);
        queue_request(MODE_CLEAR, 0, 0, 32'h0);
        queue_request(MODE_FREE, 0, 0, 32'd8);
        repeat (250) queue_random();

        run_phase(32'hFFFF_FC01, 4096, 200);
        run_phase($urandom, 8191, 200);
        run_phase(32'hFFFF_FFFF, 1, 60);
        run_phase(32'h0000_0000, 0, 40);
        run_phase($urandom, $urandom_range(64, 1024), 200);
        run_phase(32'h8000_0000, 4096, 200);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && rsp_expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
